// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // per-step control broadcast to every cell
    typedef struct packed {
        logic step;     // a word is taken this cycle
        logic remove;   // window is full: drop the oldest value
        logic s_ge_d;   // new sample >= oldest value
    } swm_ctrl_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted chain. Inserts the new sample after equal values and
// removes the first copy of the oldest value using only neighbor data.
// ----------------------------------------------------------------------------
module swm_cell
(
    input  logic              clk,
    input  swm_pkg::swm_ctrl_t ctrl,
    input  logic              valid,
    input  logic              is_med,
    input  swm_pkg::sample_t  s,
    input  swm_pkg::sample_t  d,
    input  logic              left_lt,
    input  swm_pkg::sample_t  left_v,
    input  logic              left_vge,
    input  swm_pkg::sample_t  right_a,
    output logic              lt,
    output swm_pkg::sample_t  v,
    output logic              vge,
    output swm_pkg::sample_t  a,
    output swm_pkg::sample_t  med_part
);

    swm_pkg::sample_t v_reg;
    swm_pkg::sample_t v_next;
    logic             a_ge;

    assign v   = v_reg;
    assign lt  = valid && (v_reg <= s);
    assign vge = (v_reg >= d);

    // value after insertion: keep, take the sample, or take the left neighbor
    always_comb
    begin
        if (lt)
        begin
            a    = v_reg;
            a_ge = vge;
        end
        else if (left_lt)
        begin
            a    = s;
            a_ge = ctrl.s_ge_d;
        end
        else
        begin
            a    = left_v;
            a_ge = left_vge;
        end
    end

    // first slot >= oldest value is the one that leaves; later slots shift left
    always_comb
    begin
        if (ctrl.remove && a_ge)
            v_next = right_a;
        else
            v_next = a;
    end

    assign med_part = is_med ? a : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
            v_reg <= v_next;
    end

endmodule

// ===== hw/rtl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median
// Running lower-median filter over the last K signed samples.
// ----------------------------------------------------------------------------
// Takes one sample word per clock and, once K samples are held, returns the
// lower median of the last K (sorted position (K+1)/2-1) in the cycle after
// the sample is taken; the first K-1 samples after reset or a window size
// write return nothing. The sorted window lives in a row of WINDOW_MAX cells
// that insert the new value and drop the oldest in the same clock, and the
// oldest value comes from an arrival ring read ahead into a register.
// s_axis_tready only drops while a median word waits on a stalled m_axis.
// Writing cfg_data sets K (0 reads as 1, values above WINDOW_MAX saturate)
// and empties the window; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [31:0] median
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]  cfg_data
);

    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW      = $clog2(WINDOW_MAX + 1);
    localparam int K_RESET = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;

    logic [CW-1:0] k_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [CW-1:0] k_cfg;
    logic [CW:0]   wsum;
    logic [CW:0]   ptr_inc;
    logic [AW-1:0] waddr;
    logic [AW-1:0] med_idx;
    logic          accept;
    logic          cfg_wr;
    logic          full;

    swm_pkg::sample_t s;
    swm_pkg::sample_t d;
    swm_pkg::sample_t ring_q_reg;
    swm_pkg::sample_t ring_mem [WINDOW_MAX];
    swm_pkg::sample_t med_or;
    swm_pkg::sample_t m_data_reg;
    logic             m_valid_reg;

    swm_pkg::swm_ctrl_t ctrl;

    logic             lt_w       [WINDOW_MAX];
    logic             vge_w      [WINDOW_MAX];
    swm_pkg::sample_t v_w        [WINDOW_MAX];
    swm_pkg::sample_t a_w        [WINDOW_MAX];
    swm_pkg::sample_t med_part_w [WINDOW_MAX];

    assign s             = swm_pkg::sample_t'(s_axis_tdata);
    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid && cfg_ready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // window size with zero and overrange clamped
    always_comb
    begin
        if (cfg_data == '0)
            k_cfg = CW'(1);
        else if (32'(cfg_data) > 32'(WINDOW_MAX))
            k_cfg = CW'(WINDOW_MAX);
        else
            k_cfg = CW'(cfg_data);
    end

    assign full    = ((CW+1)'(fill_reg) + (CW+1)'(1)) == (CW+1)'(k_reg);
    assign med_idx = AW'((k_reg - CW'(1)) >> 1);

    // write slot of the new sample in the arrival ring
    always_comb
    begin
        wsum = (CW+1)'(ptr_reg) + (CW+1)'(fill_reg);
        if (wsum >= (CW+1)'(k_reg))
            wsum = wsum - (CW+1)'(k_reg);
        waddr = AW'(wsum);
    end

    always_comb
    begin
        ptr_inc = (CW+1)'(ptr_reg) + (CW+1)'(1);
        if (ptr_inc >= (CW+1)'(k_reg))
            ptr_inc = '0;
    end

    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (cfg_wr)
        begin
            ptr_next  = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            if (full)
                ptr_next = AW'(ptr_inc);
            else
                fill_next = fill_reg + CW'(1);
        end
    end

    // an empty window means the new sample is also the oldest one
    assign d = (fill_reg == '0) ? s : ring_q_reg;

    assign ctrl.step   = accept;
    assign ctrl.remove = full;
    assign ctrl.s_ge_d = (s >= d);

    always_ff @(posedge clk)
    begin
        if (accept)
            ring_mem[waddr] <= s;
        if (accept && (waddr == ptr_next))
            ring_q_reg <= s;
        else
            ring_q_reg <= ring_mem[ptr_next];
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic             left_lt;
        logic             left_vge;
        swm_pkg::sample_t left_v;
        swm_pkg::sample_t right_a;

        if (i == 0)
        begin : g_head
            assign left_lt  = 1'b1;
            assign left_vge = 1'b0;
            assign left_v   = '0;
        end
        else
        begin : g_body
            assign left_lt  = lt_w[i-1];
            assign left_vge = vge_w[i-1];
            assign left_v   = v_w[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_tail
            assign right_a = a_w[i];
        end
        else
        begin : g_mid
            assign right_a = a_w[i+1];
        end

        swm_cell u_cell
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .valid    (CW'(i) < fill_reg),
            .is_med   (AW'(i) == med_idx),
            .s        (s),
            .d        (d),
            .left_lt  (left_lt),
            .left_v   (left_v),
            .left_vge (left_vge),
            .right_a  (right_a),
            .lt       (lt_w[i]),
            .v        (v_w[i]),
            .vge      (vge_w[i]),
            .a        (a_w[i]),
            .med_part (med_part_w[i])
        );
    end

    // one-hot select of the median slot
    always_comb
    begin
        med_or = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
            med_or = med_or | med_part_w[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= CW'(K_RESET);
            fill_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                k_reg <= k_cfg;
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (accept && full)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && full)
            m_data_reg <= med_or;
    end

endmodule

// ===== tb/sv/sliding_window_median_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking bench for the running lower-median filter.
// ----------------------------------------------------------------------------
// A directed table covers the sample extremes, the reset size and sizes 0, 2
// and 4, and runs of equal values. Random phases follow, each with its own
// window size, including 64 and sizes that saturate. Every median word is
// checked against a typed-in value or a window predictor kept inside the
// bench. Both stream sides idle in random bursts. One long receiver hold
// backs the block up into its input.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;

    localparam int          WINDOW_MAX    = 64;
    localparam int unsigned ITEMS_TOTAL   = 2000;
    localparam int unsigned NO_IDLE_TAIL  = 250;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned SETTLE        = 6;
    localparam int unsigned MAX_PRINTS    = 40;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;     // sample word, or window size in [6:0]
        logic        known;     // median below is typed in
        logic [31:0] median;
    } stim_row_t;

    localparam int DIR_N = 23;
    localparam stim_row_t DIR_ROWS [0:DIR_N-1] = '{
        // window of 3 after reset: two words fill, third gives the middle
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 32'h0},
        // size zero acts as one: every word comes straight back
        '{ROW_CFG,    32'd0,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 32'h5555_5555, 1'b1, 32'h5555_5555},
        '{ROW_SAMPLE, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA},
        // size two: lower median is the minimum, equal values
        '{ROW_CFG,    32'd2,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd5,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd5,         1'b1, 32'd5},
        '{ROW_SAMPLE, 32'd5,         1'b1, 32'd5},
        '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b1, 32'hFFFF_FFF9},
        '{ROW_SAMPLE, 32'd9,         1'b0, 32'h0},
        // size four with duplicates leaving one copy at a time
        '{ROW_CFG,    32'd4,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd3,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd3,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd1,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd3,         1'b1, 32'd3},
        '{ROW_SAMPLE, 32'd1,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd3,         1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd2,         1'b0, 32'h0}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata;     // [31:0] sample
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata;     // [31:0] median
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [swm_pkg::CFG_W-1:0]    cfg_data;

    // window predictor
    swm_pkg::sample_t arrivals [WINDOW_MAX];
    swm_pkg::sample_t ordered  [WINDOW_MAX];
    int unsigned      held;
    int unsigned      oldest;
    logic [6:0]       win_reg;

    swm_pkg::sample_t median_q [$];
    int unsigned      samples_sent;
    int unsigned      errors;
    bit               idle_on;
    bit               hold_request;

    sliding_window_median #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned window_len(input logic [6:0] size);
        int unsigned k;
        k = 32'(size);
        if (k < 1)
            k = 1;
        if (k > WINDOW_MAX)
            k = WINDOW_MAX;
        return k;
    endfunction

    // Takes one sample into the window; returns 1 with the lower median once full.
    function automatic bit median_step(input swm_pkg::sample_t s,
                                       output swm_pkg::sample_t med);
        int unsigned      k;
        int unsigned      wpos;
        int unsigned      pos;
        int unsigned      i;
        swm_pkg::sample_t leaving;
        k   = window_len(win_reg);
        med = '0;
        if (held >= k || oldest >= k)
        begin
            held   = 0;
            oldest = 0;
        end
        wpos = oldest + held;
        if (wpos >= k)
            wpos -= k;
        arrivals[wpos] = s;
        // new value goes after any equal ones
        pos = 0;
        while (pos < held && ordered[pos] <= s)
            pos++;
        for (i = held; i > pos; i--)
            ordered[i] = ordered[i-1];
        ordered[pos] = s;
        held++;
        if (held < k)
            return 1'b0;
        med     = ordered[(k + 1) / 2 - 1];
        leaving = arrivals[oldest];
        pos = 0;
        while (pos < held && ordered[pos] != leaving)
            pos++;
        for (i = pos; i + 1 < held; i++)
            ordered[i] = ordered[i+1];
        held--;
        oldest++;
        if (oldest >= k)
            oldest = 0;
        return 1'b1;
    endfunction

    function automatic swm_pkg::sample_t rand_sample(input bit dup_heavy);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (dup_heavy && pick < 6)
            return swm_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
        case (pick)
            0:       return swm_pkg::sample_t'(32'h8000_0000);
            1:       return swm_pkg::sample_t'(32'h7FFF_FFFF);
            2:       return swm_pkg::sample_t'(int'($urandom_range(0, 20)) - 10);
            default: return swm_pkg::sample_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input swm_pkg::sample_t got,
                                   input swm_pkg::sample_t want);
        if (errors < MAX_PRINTS)
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic push_sample(input swm_pkg::sample_t v, input bit known,
                               input swm_pkg::sample_t known_med);
        swm_pkg::sample_t med;
        bit               has_med;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has_med = median_step(v, med);
        if (known)
            median_q = {median_q, known_med};
        else if (has_med)
            median_q = {median_q, med};
        samples_sent++;
    endtask

    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16))
            @(posedge clk);
    endtask

    // stop sending and wait for every outstanding median word
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [6:0] size);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        win_reg = size;
        held    = 0;
        oldest  = 0;
    endtask

    // receiver side: ready bursts, random stalls, one long hold on request
    initial
    begin : rx_side
        int unsigned span;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                span = 0;
                while (span < LONG_HOLD)
                begin
                    @(posedge clk);
                    span++;
                end
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16))
                    @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20))
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : median_check
        swm_pkg::sample_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (median_q.size() == 0)
                report_mismatch("median word with none pending", m_axis_tdata, '0);
            else
            begin
                want = median_q.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("median", m_axis_tdata, want);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned r;
        int unsigned n;
        int unsigned i;
        int unsigned k_eff;
        int unsigned half;
        int unsigned pick;
        logic [6:0]  wsize;
        bit          dup_heavy;
        logic [6:0]  corner_sizes [3];

        corner_sizes  = '{7'd64, 7'd127, 7'd100};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        win_reg       = 7'd3;
        held          = 0;
        oldest        = 0;
        samples_sent  = 0;
        errors        = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_N; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                write_window(DIR_ROWS[r].value[6:0]);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    sender_gap();
                push_sample(DIR_ROWS[r].value, DIR_ROWS[r].known, DIR_ROWS[r].median);
            end
        end

        // window of one with a long receiver hold: the block must back up
        write_window(7'd1);
        hold_request = 1'b1;
        for (i = 0; i < 48; i++)
            push_sample(rand_sample(1'b0), 1'b0, '0);

        r = 0;
        while (samples_sent < ITEMS_TOTAL)
        begin
            if (r < 3)
                wsize = corner_sizes[r];
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    wsize = 7'($urandom_range(1, 8));
                else if (pick == 7)
                    wsize = 7'($urandom_range(9, 63));
                else if (pick == 8)
                    wsize = 7'($urandom_range(64, 127));
                else
                    wsize = 7'd0;
            end
            r++;
            idle_on = (samples_sent + NO_IDLE_TAIL < ITEMS_TOTAL);
            write_window(wsize);
            k_eff     = window_len(wsize);
            n         = k_eff + $urandom_range(0, 2 * k_eff + 16);
            half      = (idle_on && $urandom_range(0, 3) == 0) ? n / 2 : n + 1;
            dup_heavy = ($urandom_range(0, 2) == 0);
            for (i = 0; i < n; i++)
            begin
                if (i == half)
                    drain();
                if (idle_on && $urandom_range(0, 3) == 0)
                    sender_gap();
                push_sample(rand_sample(dup_heavy), 1'b0, '0);
            end
        end

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
